// ===== hw/rtl/calu_pkg.sv =====
// Shared types and opcode constants for the accumulator/flag ALU.
package calu_pkg;

    localparam int OP_W = 5;

    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
    localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
    localparam logic [OP_W-1:0] OP_CP    = 5'd4;
    localparam logic [OP_W-1:0] OP_INC   = 5'd5;
    localparam logic [OP_W-1:0] OP_DEC   = 5'd6;
    localparam logic [OP_W-1:0] OP_ADDHL = 5'd7;
    localparam logic [OP_W-1:0] OP_ADDSP = 5'd8;
    localparam logic [OP_W-1:0] OP_AND   = 5'd9;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd10;
    localparam logic [OP_W-1:0] OP_OR    = 5'd11;
    localparam logic [OP_W-1:0] OP_BIT   = 5'd12;
    localparam logic [OP_W-1:0] OP_RL    = 5'd13;
    localparam logic [OP_W-1:0] OP_RLC   = 5'd14;
    localparam logic [OP_W-1:0] OP_RR    = 5'd15;
    localparam logic [OP_W-1:0] OP_RRC   = 5'd16;
    localparam logic [OP_W-1:0] OP_SLA   = 5'd17;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd18;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd19;
    localparam logic [OP_W-1:0] OP_SWAP  = 5'd20;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd21;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [7:0]      operand_byte;
        logic [15:0]     operand_word;
        logic [15:0]     word_base;
        logic [2:0]      bit_index;
        logic [3:0]      load_flags;
    } t_calu_in;

    typedef struct packed {
        logic [7:0]  accumulator;
        logic [3:0]  flags;
        logic [7:0]  result_byte;
        logic [15:0] result_word;
    } t_calu_out;

endpackage

// ===== hw/rtl/calu_exec.sv =====
// Combinational execute stage: one operation against the current accumulator and flags.
module calu_exec (
    input  calu_pkg::t_calu_in  i_item,
    input  logic [7:0]          i_acc,
    input  logic [3:0]          i_flags,
    output calu_pkg::t_calu_out o_res
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cf;
    logic        add_c;
    logic        sub_c;
    logic [8:0]  add_s;
    logic [4:0]  add_h;
    logic [8:0]  sub_d;
    logic [4:0]  sub_h;
    logic [16:0] hl_s;
    logic [12:0] hl_h;
    logic [15:0] sp_s;
    logic [4:0]  sp_h;
    logic [8:0]  sp_c;
    logic [7:0]  inc_v;
    logic [7:0]  dec_v;

    assign a     = i_acc;
    assign b     = i_item.operand_byte;
    assign cf    = i_flags[calu_pkg::FLAG_C];
    assign add_c = (i_item.opcode == calu_pkg::OP_ADC) ? cf : 1'b0;
    assign sub_c = (i_item.opcode == calu_pkg::OP_SBC) ? cf : 1'b0;

    assign add_s = {1'b0, a} + {1'b0, b} + {8'd0, add_c};
    assign add_h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_c};
    // bit 8/4 of the wrapped difference is the borrow
    assign sub_d = {1'b0, a} - {1'b0, b} - {8'd0, sub_c};
    assign sub_h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_c};

    assign hl_s  = {1'b0, i_item.word_base} + {1'b0, i_item.operand_word};
    assign hl_h  = {1'b0, i_item.word_base[11:0]} + {1'b0, i_item.operand_word[11:0]};
    assign sp_s  = i_item.word_base + {{8{b[7]}}, b};
    assign sp_h  = {1'b0, i_item.word_base[3:0]} + {1'b0, b[3:0]};
    assign sp_c  = {1'b0, i_item.word_base[7:0]} + {1'b0, b};

    assign inc_v = b + 8'd1;
    assign dec_v = b - 8'd1;

    always_comb begin
        logic [7:0] acc_n;
        logic [3:0] flg_n;
        logic [7:0] rb;
        logic [15:0] rw;
        logic [7:0] sh;
        logic       sh_c;
        logic       is_sh;
        logic [7:0] lg;

        acc_n = a;
        flg_n = i_flags;
        rb    = 8'd0;
        rw    = 16'd0;
        sh    = 8'd0;
        sh_c  = 1'b0;
        is_sh = 1'b0;
        lg    = 8'd0;

        case (i_item.opcode)
            calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
                acc_n = add_s[7:0];
                flg_n = {(add_s[7:0] == 8'd0), 1'b0, add_h[4], add_s[8]};
            end
            calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP: begin
                if (i_item.opcode != calu_pkg::OP_CP) begin
                    acc_n = sub_d[7:0];
                end
                flg_n = {(sub_d[7:0] == 8'd0), 1'b1, sub_h[4], sub_d[8]};
            end
            calu_pkg::OP_INC: begin
                rb = inc_v;
                flg_n = {(inc_v == 8'd0), 1'b0, (b[3:0] == 4'hF), cf};
            end
            calu_pkg::OP_DEC: begin
                rb = dec_v;
                flg_n = {(dec_v == 8'd0), 1'b1, (b[3:0] == 4'h0), cf};
            end
            calu_pkg::OP_ADDHL: begin
                rw = hl_s[15:0];
                flg_n = {i_flags[calu_pkg::FLAG_Z], 1'b0, hl_h[12], hl_s[16]};
            end
            calu_pkg::OP_ADDSP: begin
                rw = sp_s;
                flg_n = {1'b0, 1'b0, sp_h[4], sp_c[8]};
            end
            calu_pkg::OP_AND, calu_pkg::OP_XOR, calu_pkg::OP_OR: begin
                if (i_item.opcode == calu_pkg::OP_AND) begin
                    lg = a & b;
                end else if (i_item.opcode == calu_pkg::OP_XOR) begin
                    lg = a ^ b;
                end else begin
                    lg = a | b;
                end
                acc_n = lg;
                flg_n = {(lg == 8'd0), 1'b0, (i_item.opcode == calu_pkg::OP_AND), 1'b0};
            end
            calu_pkg::OP_BIT: begin
                flg_n = {~b[i_item.bit_index], 1'b0, 1'b1, cf};
            end
            calu_pkg::OP_RL: begin
                is_sh = 1'b1;
                sh    = {b[6:0], cf};
                sh_c  = b[7];
            end
            calu_pkg::OP_RLC: begin
                is_sh = 1'b1;
                sh    = {b[6:0], b[7]};
                sh_c  = b[7];
            end
            calu_pkg::OP_RR: begin
                is_sh = 1'b1;
                sh    = {cf, b[7:1]};
                sh_c  = b[0];
            end
            calu_pkg::OP_RRC: begin
                is_sh = 1'b1;
                sh    = {b[0], b[7:1]};
                sh_c  = b[0];
            end
            calu_pkg::OP_SLA: begin
                is_sh = 1'b1;
                sh    = {b[6:0], 1'b0};
                sh_c  = b[7];
            end
            calu_pkg::OP_SRA: begin
                is_sh = 1'b1;
                sh    = {b[7], b[7:1]};
                sh_c  = b[0];
            end
            calu_pkg::OP_SRL: begin
                is_sh = 1'b1;
                sh    = {1'b0, b[7:1]};
                sh_c  = b[0];
            end
            calu_pkg::OP_SWAP: begin
                is_sh = 1'b1;
                sh    = {b[3:0], b[7:4]};
                sh_c  = 1'b0;
            end
            calu_pkg::OP_LOAD: begin
                acc_n = b;
                flg_n = i_item.load_flags;
            end
            default: begin
                // unused opcodes: no-op
            end
        endcase

        if (is_sh) begin
            rb    = sh;
            flg_n = {(sh == 8'd0), 1'b0, 1'b0, sh_c};
        end

        o_res.accumulator = acc_n;
        o_res.flags       = flg_n;
        o_res.result_byte = rb;
        o_res.result_word = rw;
    end

endmodule

// ===== hw/rtl/cpu_alu_with_flags.sv =====
// 8-bit accumulator ALU with Z/N/H/C flags: input register, execute stage, result register.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one operation per
// transfer; output channel (o_out_valid / i_out_ready / o_out_data) returns one
// result per operation, in order, carrying the accumulator and flags after it.
// An operation is held in the input register, then executed into the result register.
// Throughput: one operation per cycle while the receiver keeps i_out_ready high.
// The accumulator and flags are read and written by the single execute stage,
// so back-to-back operations chain with no bubble.
// The input register keeps accepting while a result waits, until both the
// result register and the input register are full; while the receiver then
// stalls, o_out_data holds steady and o_in_ready drops.
// Reset (synchronous, active low) clears the accumulator, the flags and both
// valid bits; nothing in flight survives.
module cpu_alu_with_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  calu_pkg::t_calu_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output calu_pkg::t_calu_out o_out_data
);

    logic                r_in_vld;
    calu_pkg::t_calu_in  r_in;
    logic                r_out_vld;
    calu_pkg::t_calu_out r_out;
    logic [7:0]          r_acc;
    logic [3:0]          r_flg;

    logic                w_adv;
    calu_pkg::t_calu_out n_out;

    // execute moves the held item into the result register
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    calu_exec u_exec (
        .i_item  (r_in),
        .i_acc   (r_acc),
        .i_flags (r_flg),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= 8'd0;
            r_flg     <= 4'd0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_acc     <= n_out.accumulator;
                r_flg     <= n_out.flags;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a shown result always matches the architectural state it produced
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.accumulator == r_acc && r_out.flags == r_flg))
        else $error("result register out of step with accumulator/flags");

    // an empty input register never refuses a transfer
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> o_in_ready)
        else $error("input stalled while empty");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule
